>>> rtl/sldf_pkg.sv
// shared types and constants for the sync/length/checksum deframer
`default_nettype none
package sldf_pkg;

    localparam logic [7:0]  SYNC_BYTE      = 8'h0a;
    localparam logic [8:0]  HEADER_BYTES   = 9'd2;
    localparam logic [15:0] TIMEOUT_RESET  = 16'd1000;
    localparam logic [15:0] IDLE_MAX       = 16'hffff;

    localparam logic       KIND_BYTE = 1'b0;
    localparam logic       KIND_TICK = 1'b1;
    localparam logic       OUT_BYTE  = 1'b0;
    localparam logic       OUT_STAT  = 1'b1;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_CSUM_ERR    = 2'd1;
    localparam logic [1:0] ST_TO_HUNT     = 2'd2;
    localparam logic [1:0] ST_TO_PACKET   = 2'd3;

    typedef enum logic [2:0] {
        PH_SYNC0   = 3'd0,
        PH_SYNC1   = 3'd1,
        PH_IFACE   = 3'd2,
        PH_LEN     = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CHECK   = 3'd5
    } t_phase;

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic       out_kind;
        logic [7:0] out_byte;
        logic [8:0] byte_index;
        logic [1:0] status;
        logic [8:0] packet_length;
    } t_out_item;

    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_front_req;

endpackage
`default_nettype wire

>>> rtl/sldf_front.sv
// front part: takes bytes and ticks, tracks the framing phase, emits requests
`default_nettype none
module sldf_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire sldf_pkg::t_in_item i_item,
    input  wire logic               i_cfg_wr_en,
    input  wire logic [15:0]        i_cfg_wr_data,
    output sldf_pkg::t_front_req    o_req
);

    sldf_pkg::t_phase r_phase, n_phase;
    logic [7:0]  r_sum, n_sum;
    logic [7:0]  r_len, n_len;
    logic [8:0]  r_taken, n_taken;
    logic [15:0] r_idle, n_idle;
    logic [15:0] r_timeout_ticks;

    logic [15:0] w_idle_inc;
    logic        w_timeout;
    logic        w_is_tick;
    logic        w_hunting;
    logic [8:0]  w_taken_inc;
    logic [8:0]  w_frame_len;
    logic [7:0]  w_b;

    assign w_b         = i_item.rx_byte;
    assign w_is_tick   = (i_item.kind == sldf_pkg::KIND_TICK);
    assign w_idle_inc  = (r_idle == sldf_pkg::IDLE_MAX) ? r_idle : r_idle + 16'd1;
    assign w_timeout   = (w_idle_inc >= r_timeout_ticks);
    assign w_hunting   = (r_phase == sldf_pkg::PH_SYNC0) || (r_phase == sldf_pkg::PH_SYNC1);
    assign w_taken_inc = r_taken + 9'd1;
    assign w_frame_len = sldf_pkg::HEADER_BYTES + {1'b0, r_len};

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (i_accept) begin
            if (w_is_tick) begin
                if (w_timeout) begin
                    n_phase = sldf_pkg::PH_SYNC0;
                end
            end else begin
                unique case (r_phase)
                    sldf_pkg::PH_SYNC0: begin
                        n_phase = (w_b == sldf_pkg::SYNC_BYTE) ? sldf_pkg::PH_SYNC1
                                                               : sldf_pkg::PH_SYNC0;
                    end
                    sldf_pkg::PH_SYNC1: begin
                        n_phase = (w_b == sldf_pkg::SYNC_BYTE) ? sldf_pkg::PH_IFACE
                                                               : sldf_pkg::PH_SYNC0;
                    end
                    sldf_pkg::PH_IFACE: begin
                        n_phase = sldf_pkg::PH_LEN;
                    end
                    sldf_pkg::PH_LEN: begin
                        n_phase = (w_b == 8'd0) ? sldf_pkg::PH_CHECK : sldf_pkg::PH_PAYLOAD;
                    end
                    sldf_pkg::PH_PAYLOAD: begin
                        n_phase = (w_taken_inc >= w_frame_len) ? sldf_pkg::PH_CHECK
                                                               : sldf_pkg::PH_PAYLOAD;
                    end
                    sldf_pkg::PH_CHECK: begin
                        n_phase = sldf_pkg::PH_SYNC0;
                    end
                    default: begin
                        n_phase = sldf_pkg::PH_SYNC0;
                    end
                endcase
            end
        end
    end

    // datapath and request
    always_comb begin
        n_sum   = r_sum;
        n_len   = r_len;
        n_taken = r_taken;
        n_idle  = r_idle;
        o_req   = '0;
        if (i_accept) begin
            if (w_is_tick) begin
                n_idle = w_idle_inc;
                if (w_timeout) begin
                    n_sum              = 8'd0;
                    n_len              = 8'd0;
                    n_taken            = 9'd0;
                    n_idle             = 16'd0;
                    o_req.valid        = 1'b1;
                    o_req.item.out_kind = sldf_pkg::OUT_STAT;
                    o_req.item.status  = w_hunting ? sldf_pkg::ST_TO_HUNT
                                                   : sldf_pkg::ST_TO_PACKET;
                end
            end else begin
                n_idle = 16'd0;
                unique case (r_phase)
                    sldf_pkg::PH_IFACE: begin
                        n_sum                 = w_b;
                        n_taken               = 9'd1;
                        o_req.valid           = 1'b1;
                        o_req.item.out_kind   = sldf_pkg::OUT_BYTE;
                        o_req.item.out_byte   = w_b;
                        o_req.item.byte_index = 9'd0;
                    end
                    sldf_pkg::PH_LEN: begin
                        n_sum                 = r_sum + w_b;
                        n_len                 = w_b;
                        n_taken               = sldf_pkg::HEADER_BYTES;
                        o_req.valid           = 1'b1;
                        o_req.item.out_kind   = sldf_pkg::OUT_BYTE;
                        o_req.item.out_byte   = w_b;
                        o_req.item.byte_index = 9'd1;
                    end
                    sldf_pkg::PH_PAYLOAD: begin
                        n_sum                 = r_sum + w_b;
                        n_taken               = w_taken_inc;
                        o_req.valid           = 1'b1;
                        o_req.item.out_kind   = sldf_pkg::OUT_BYTE;
                        o_req.item.out_byte   = w_b;
                        o_req.item.byte_index = r_taken;
                    end
                    sldf_pkg::PH_CHECK: begin
                        n_sum               = 8'd0;
                        n_len               = 8'd0;
                        n_taken             = 9'd0;
                        o_req.valid         = 1'b1;
                        o_req.item.out_kind = sldf_pkg::OUT_STAT;
                        if (w_b == r_sum) begin
                            o_req.item.status        = sldf_pkg::ST_OK;
                            o_req.item.packet_length = w_frame_len;
                        end else begin
                            o_req.item.status        = sldf_pkg::ST_CSUM_ERR;
                        end
                    end
                    default: begin
                        // hunting phases only move the phase
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= sldf_pkg::PH_SYNC0;
            r_sum           <= 8'd0;
            r_len           <= 8'd0;
            r_taken         <= 9'd0;
            r_idle          <= 16'd0;
            r_timeout_ticks <= sldf_pkg::TIMEOUT_RESET;
        end else begin
            r_phase <= n_phase;
            r_sum   <= n_sum;
            r_len   <= n_len;
            r_taken <= n_taken;
            r_idle  <= n_idle;
            if (i_cfg_wr_en) begin
                r_timeout_ticks <= i_cfg_wr_data;
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/sldf_queue.sv
// back part: result queue with a registered head that drives the result ports
`default_nettype none
module sldf_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire sldf_pkg::t_front_req i_req,
    input  wire logic                 i_pop,
    output logic                      o_full,
    output logic                      o_empty,
    output sldf_pkg::t_out_item       o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    sldf_pkg::t_out_item r_mem [DEPTH];
    sldf_pkg::t_out_item r_head;
    logic                r_head_valid;
    logic [PW-1:0]       r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]       r_cnt;

    logic w_head_free;
    logic w_mem_nonempty;
    logic w_take_mem;
    logic w_push_head;
    logic w_push_mem;

    assign o_full         = (r_cnt == FULL_CNT);
    assign o_empty        = !r_head_valid;
    assign o_head         = r_head;
    assign w_head_free    = !r_head_valid || i_pop;
    assign w_mem_nonempty = (r_cnt != '0);
    assign w_take_mem     = w_head_free && w_mem_nonempty;
    // bypass straight into the head when nothing older waits
    assign w_push_head    = i_req.valid && w_head_free && !w_mem_nonempty;
    assign w_push_mem     = i_req.valid && !w_push_head;

    always_ff @(posedge i_clk) begin
        if (w_push_mem) begin
            r_mem[r_wr_ptr] <= i_req.item;
        end
        if (w_take_mem) begin
            r_head <= r_mem[r_rd_ptr];
        end else if (w_push_head) begin
            r_head <= i_req.item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= 1'b0;
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
            r_cnt        <= '0;
        end else begin
            if (w_head_free) begin
                r_head_valid <= w_take_mem || w_push_head;
            end
            if (w_push_mem) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PW'(1);
            end
            if (w_take_mem) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PW'(1);
            end
            priority if (w_push_mem && !w_take_mem) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (w_take_mem && !w_push_mem) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/sync_length_checksum_deframer_top.sv
// top level of the sync/length/checksum deframer
//
// channel   direction  handshake           payload
// input     in         push / full         i_item   (kind, rx_byte)
// result    out        empty / pop         o_result (out_kind .. packet_length)
// config    in         i_cfg_wr_en         i_cfg_wr_data (timeout_ticks)
//
// one item accepted per cycle unless full; its result, if any, shows on the
// next cycle when no older result waits, otherwise behind the older ones in order
// full rises once QUEUE_DEPTH results wait behind the result register
// pop and push may fire in the same cycle
// synchronous reset clears phase, counters and queue; timeout_ticks returns to 1000
`default_nettype none
module sync_length_checksum_deframer_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire sldf_pkg::t_in_item i_item,
    output logic                    empty,
    input  wire logic               pop,
    output sldf_pkg::t_out_item     o_result,
    input  wire logic               i_cfg_wr_en,
    input  wire logic [15:0]        i_cfg_wr_data
);

    sldf_pkg::t_front_req w_req;
    logic                 w_accept;

    assign w_accept = push && !full;

    sldf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_item        (i_item),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_req         (w_req)
    );

    sldf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (o_result)
    );

endmodule
`default_nettype wire

>>> rtl/sldf_checker.sv
// port-level checks for the deframer top, bound to it
`default_nettype none
module sldf_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                empty,
    input wire logic                pop,
    input wire sldf_pkg::t_out_item o_result
);

    // a waiting result that is not popped stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("waiting result changed without pop");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("queue not empty after reset");

    a_byte_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.out_kind == sldf_pkg::OUT_BYTE)
        |-> (o_result.status == sldf_pkg::ST_OK && o_result.packet_length == 9'd0))
        else $error("byte request carries status fields");

    a_stat_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.out_kind == sldf_pkg::OUT_STAT)
        |-> (o_result.out_byte == 8'd0 && o_result.byte_index == 9'd0))
        else $error("status request carries byte fields");

    a_len_on_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.out_kind == sldf_pkg::OUT_STAT)
        |-> ((o_result.status == sldf_pkg::ST_OK) ? (o_result.packet_length >= 9'd2)
                                                  : (o_result.packet_length == 9'd0)))
        else $error("packet length inconsistent with status");

endmodule

bind sync_length_checksum_deframer_top sldf_checker u_sldf_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .empty    (empty),
    .pop      (pop),
    .o_result (o_result)
);
`default_nettype wire
